### src/pawt_pkg.sv
// Shared types, codes and field widths of the pending acknowledgement window tracker.
`timescale 1ns / 1ps
package pawt_pkg;

   localparam int VER_W     = 63;
   localparam int TASK_W    = 16;
   localparam int TASKV_W   = 17;
   localparam int TIME_W    = 32;
   localparam int TMO_W     = 16;
   localparam int STAT_W    = 2;
   localparam int RING_SIZE = 32;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_TICK   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } stat_type;

   typedef enum logic [4:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_ADD_MATCH,
      ACT_FILL,
      ACT_FILL_LAST,
      ACT_OPOS_CLR,
      ACT_OPOS_ONE,
      ACT_OPOS_INC,
      ACT_INSERT,
      ACT_FREE,
      ACT_FREE_ADV,
      ACT_WS_INC,
      ACT_OREL,
      ACT_OREL_DEL,
      ACT_OCLR,
      ACT_SET_LCT,
      ACT_EMIT_STAT
   } act_type;

   typedef enum logic [1:0] {
      RA_WS   = 2'd0,
      RA_IDXF = 2'd1,
      RA_PREV = 2'd2
   } ra_type;

   typedef struct packed {
      act_type  act;
      ra_type   ra;
      stat_type code;
   } cmd_type;

   typedef struct packed {
      logic win_empty;
      logic cnt_small;
      logic idx_eq_we;
      logic next_ne_ws;
      logic first_eq_rv1;
      logic ring_hit;
      logic rv_zero;
      logic ws_eq_idx;
      logic rexp_lt_now;
      logic lct_eq_now;
      logic more;
      logic ov_cnt_zero;
      logic ov_full;
      logic key_lt_ov0;
      logic key_eq_ov0;
      logic opos_lt_cnt;
      logic scan_go;
      logic pos_eq_key;
      logic oexp_lt_now;
      logic out_free;
      logic ring_rel_ok;
      logic ov_rel_ok;
   } dp_stat_type;

endpackage

### src/pending_ack_window_tracker_top.sv
// Top level of the pending acknowledgement window tracker.
//
// req channel: one operation per transfer (add range, remove, timeout tick,
// clear all), selected by req_tuser. rsp channel: zero or more release
// transfers (rsp_tuser high), then one status transfer with rsp_tlast high.
// csr channel: writes the timeout in seconds (reset value 30), always ready.
//
// One operation is worked at a time; req_tready is high only when idle.
// The ring index is the low bits of the version, taken at the transfer.
// An add into the ring fills one slot per version of the range, after a
// window check; an overflow insert scans for the place of each version and
// shifts the entries above it; remove, tick and clear visit one slot or entry
// per step. When the walk ends, the status goes into the output register
// and the controller returns to idle, where the next request is taken.
// Results leave through one output register, so a stalled rsp side holds
// the walk on the step that would emit; the next request is taken while the
// final status still waits. Synchronous reset empties the ring and window,
// the overflow count and the tick time.
`timescale 1ns / 1ps
module pending_ack_window_tracker_top #(
   parameter int OVERFLOW_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_version, last_version, task_id, task_present, now_seconds, pad
   input  logic [175:0] req_tdata,
   // op
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // released_task, released_version, status, pad
   output logic [87:0]  rsp_tdata,
   // kind
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_wdata
);
   import pawt_pkg::*;

   cmd_type            cmd;
   dp_stat_type        st;
   logic               kind;
   logic [TASK_W-1:0]  rel_task;
   logic [VER_W-1:0]   rel_ver;
   logic [STAT_W-1:0]  stat;

   assign csr_ready = 1'b1;

   pawt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   pawt_dp #(
      .OVERFLOW_DEPTH (OVERFLOW_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .st          (st),
      .req_op      (req_tuser),
      .req_first   (req_tdata[62:0]),
      .req_last    (req_tdata[125:63]),
      .req_task    (req_tdata[141:126]),
      .req_present (req_tdata[142]),
      .req_now     (req_tdata[174:143]),
      .csr_valid   (csr_valid),
      .csr_wdata   (csr_wdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_kind    (kind),
      .rsp_task    (rel_task),
      .rsp_version (rel_ver),
      .rsp_status  (stat),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {7'b0, stat, rel_ver, rel_task};
   assign rsp_tuser = kind;

endmodule

### src/pawt_dp.sv
// Datapath: ring and overflow tables, window pointers and output register.
`timescale 1ns / 1ps
module pawt_dp #(
   parameter int OVERFLOW_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pawt_pkg::cmd_type            cmd,
   output pawt_pkg::dp_stat_type        st,
   input  logic [1:0]                   req_op,
   input  logic [pawt_pkg::VER_W-1:0]   req_first,
   input  logic [pawt_pkg::VER_W-1:0]   req_last,
   input  logic [pawt_pkg::TASK_W-1:0]  req_task,
   input  logic                         req_present,
   input  logic [pawt_pkg::TIME_W-1:0]  req_now,
   input  logic                         csr_valid,
   input  logic [pawt_pkg::TMO_W-1:0]   csr_wdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic                         rsp_kind,
   output logic [pawt_pkg::TASK_W-1:0]  rsp_task,
   output logic [pawt_pkg::VER_W-1:0]   rsp_version,
   output logic [pawt_pkg::STAT_W-1:0]  rsp_status,
   output logic                         rsp_last
);
   import pawt_pkg::*;

   localparam int IW  = $clog2(RING_SIZE);
   localparam int OCW = $clog2(OVERFLOW_DEPTH + 1);
   localparam int OIW = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
      return (x == IW'(RING_SIZE - 1)) ? '0 : x + 1'b1;
   endfunction

   function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] x);
      return (x == '0) ? IW'(RING_SIZE - 1) : x - 1'b1;
   endfunction

   logic [VER_W-1:0]   rv_ff [RING_SIZE];
   logic [TASKV_W-1:0] rt_ff [RING_SIZE];
   logic [TIME_W-1:0]  re_ff [RING_SIZE];
   logic [VER_W-1:0]   ov_ff [OVERFLOW_DEPTH];
   logic [TASKV_W-1:0] ot_ff [OVERFLOW_DEPTH];
   logic [TIME_W-1:0]  oe_ff [OVERFLOW_DEPTH];

   op_type             op_ff, op_in;
   logic [VER_W-1:0]   first_ff, first_in, last_ff, last_in, vcur_ff, vcur_in;
   logic [TASKV_W-1:0] task_ff, task_in;
   logic [TIME_W-1:0]  now_ff, now_in, exp_ff, exp_in, lct_ff, lct_in;
   logic [TMO_W-1:0]   tmo_ff, tmo_in;
   logic [IW-1:0]      rf_ff, rf_in, rl_ff, rl_in, ptr_ff, ptr_in;
   logic [IW-1:0]      ws_ff, ws_in, we_ff, we_in;
   logic [OCW-1:0]     opos_ff, opos_in, ocnt_ff, ocnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in, rsp_last_ff, rsp_last_in;
   logic [TASK_W-1:0]  rsp_task_ff, rsp_task_in;
   logic [VER_W-1:0]   rsp_ver_ff, rsp_ver_in;
   logic [STAT_W-1:0]  rsp_stat_ff, rsp_stat_in;

   logic [IW-1:0]      ra_addr;
   logic [VER_W-1:0]   rd_v, key, diff;
   logic [TASKV_W-1:0] rd_t;
   logic [TIME_W-1:0]  rd_e;
   logic [OIW-1:0]     opos_idx;
   logic [TIME_W:0]    exp_sum;
   logic               out_free;
   logic               more;

   assign exp_sum = {1'b0, req_now} + {{(TIME_W-TMO_W+1){1'b0}}, tmo_ff};

   always_comb begin
      unique case (cmd.ra)
         RA_IDXF: ra_addr = rf_ff;
         RA_PREV: ra_addr = wrap_dec(rf_ff);
         default: ra_addr = ws_ff;
      endcase
   end

   assign rd_v     = rv_ff[ra_addr];
   assign rd_t     = rt_ff[ra_addr];
   assign rd_e     = re_ff[ra_addr];
   assign opos_idx = opos_ff[OIW-1:0];
   assign diff     = last_ff - first_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign more     = (vcur_ff < last_ff);
   assign key      = (op_ff == OP_REMOVE) ? first_ff : (more ? vcur_ff : last_ff);

   always_comb begin
      st.win_empty    = (ws_ff == we_ff);
      st.cnt_small    = (last_ff < first_ff) || (diff < VER_W'(RING_SIZE));
      st.idx_eq_we    = (rf_ff == we_ff);
      st.next_ne_ws   = (wrap_inc(rf_ff) != ws_ff);
      st.first_eq_rv1 = ({1'b0, first_ff} == ({1'b0, rd_v} + 64'd1));
      st.ring_hit     = (rd_v == first_ff);
      st.rv_zero      = (rd_v == '0);
      st.ws_eq_idx    = (ws_ff == rf_ff);
      st.rexp_lt_now  = (rd_e < now_ff);
      st.lct_eq_now   = (lct_ff == now_ff);
      st.more         = more;
      st.ov_cnt_zero  = (ocnt_ff == '0);
      st.ov_full      = (ocnt_ff >= OCW'(OVERFLOW_DEPTH));
      st.key_lt_ov0   = (key < ov_ff[0]);
      st.key_eq_ov0   = (key == ov_ff[0]);
      st.opos_lt_cnt  = (opos_ff < ocnt_ff);
      st.scan_go      = (opos_ff < ocnt_ff) && (key > ov_ff[opos_idx]);
      st.pos_eq_key   = (ov_ff[opos_idx] == key);
      st.oexp_lt_now  = (oe_ff[opos_idx] < now_ff);
      st.out_free     = out_free;
      st.ring_rel_ok  = out_free || !rd_t[TASKV_W-1];
      st.ov_rel_ok    = out_free || !ot_ff[opos_idx][TASKV_W-1];
   end

   always_comb begin
      op_in = op_ff;  first_in = first_ff;  last_in = last_ff;  vcur_in = vcur_ff;
      task_in = task_ff;  now_in = now_ff;
      exp_in = exp_ff;  lct_in = lct_ff;  rf_in = rf_ff;  rl_in = rl_ff;
      ptr_in = ptr_ff;  ws_in = ws_ff;  we_in = we_ff;
      opos_in = opos_ff;  ocnt_in = ocnt_ff;
      tmo_in = csr_valid ? csr_wdata : tmo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in = rsp_kind_ff;  rsp_last_in = rsp_last_ff;  rsp_task_in = rsp_task_ff;
      rsp_ver_in = rsp_ver_ff;  rsp_stat_in = rsp_stat_ff;
      unique case (cmd.act)
         ACT_LOAD: begin
            op_in    = op_type'(req_op);
            first_in = req_first;
            last_in  = req_last;
            vcur_in  = req_first;
            task_in  = req_present ? {1'b1, req_task} : '0;
            now_in   = req_now;
            exp_in   = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
            rf_in    = req_first[IW-1:0];
            rl_in    = req_last[IW-1:0];
         end
         ACT_ADD_MATCH: begin
            if (ws_ff == we_ff) begin
               ws_in = rf_ff;
            end
            we_in  = wrap_inc(rl_ff);
            ptr_in = rf_ff;
         end
         ACT_FILL: begin
            ptr_in  = wrap_inc(ptr_ff);
            vcur_in = vcur_ff + 1'b1;
         end
         ACT_OPOS_CLR: opos_in = '0;
         ACT_OPOS_ONE: opos_in = OCW'(1);
         ACT_OPOS_INC: opos_in = opos_ff + 1'b1;
         ACT_INSERT: begin
            ocnt_in = ocnt_ff + 1'b1;
            vcur_in = vcur_ff + 1'b1;
         end
         ACT_FREE, ACT_FREE_ADV: begin
            if (cmd.act == ACT_FREE_ADV) begin
               ws_in = wrap_inc(ra_addr);
            end
            if (rd_t[TASKV_W-1]) begin
               rsp_valid_in = 1'b1;  rsp_kind_in = 1'b1;  rsp_last_in = 1'b0;
               rsp_task_in  = rd_t[TASK_W-1:0];  rsp_ver_in = rd_v;  rsp_stat_in = ST_OK;
            end
         end
         ACT_WS_INC: ws_in = wrap_inc(ws_ff);
         ACT_OREL, ACT_OREL_DEL: begin
            if (cmd.act == ACT_OREL) begin
               opos_in = opos_ff + 1'b1;
            end else begin
               ocnt_in = ocnt_ff - 1'b1;
            end
            if (ot_ff[opos_idx][TASKV_W-1]) begin
               rsp_valid_in = 1'b1;  rsp_kind_in = 1'b1;  rsp_last_in = 1'b0;
               rsp_task_in  = ot_ff[opos_idx][TASK_W-1:0];
               rsp_ver_in   = ov_ff[opos_idx];
               rsp_stat_in  = ST_OK;
            end
         end
         ACT_OCLR: ocnt_in = '0;
         ACT_SET_LCT: lct_in = now_ff;
         ACT_EMIT_STAT: begin
            rsp_valid_in = 1'b1;  rsp_kind_in = 1'b0;  rsp_last_in = 1'b1;
            rsp_task_in  = '0;  rsp_ver_in = '0;  rsp_stat_in = cmd.code;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;  first_ff <= first_in;  last_ff <= last_in;  vcur_ff <= vcur_in;
      task_ff <= task_in;  now_ff <= now_in;
      exp_ff <= exp_in;  rf_ff <= rf_in;  rl_ff <= rl_in;  ptr_ff <= ptr_in;
      opos_ff <= opos_in;
      rsp_kind_ff <= rsp_kind_in;  rsp_last_ff <= rsp_last_in;  rsp_task_ff <= rsp_task_in;
      rsp_ver_ff <= rsp_ver_in;  rsp_stat_ff <= rsp_stat_in;
      if (reset) begin
         ws_ff <= '0;  we_ff <= '0;  ocnt_ff <= '0;  lct_ff <= '0;
         tmo_ff <= TMO_W'(30);  rsp_valid_ff <= 1'b0;
      end else begin
         ws_ff <= ws_in;  we_ff <= we_in;  ocnt_ff <= ocnt_in;  lct_ff <= lct_in;
         tmo_ff <= tmo_in;  rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_SIZE; i++) begin
            rv_ff[i] <= '0;
            rt_ff[i] <= '0;
            re_ff[i] <= '0;
         end
      end else begin
         unique case (cmd.act)
            ACT_FILL: begin
               rv_ff[ptr_ff] <= vcur_ff;
               re_ff[ptr_ff] <= exp_ff;
            end
            ACT_FILL_LAST: begin
               rv_ff[rl_ff] <= last_ff;
               rt_ff[rl_ff] <= task_ff;
               re_ff[rl_ff] <= exp_ff;
            end
            ACT_FREE, ACT_FREE_ADV: begin
               rv_ff[ra_addr] <= '0;
               rt_ff[ra_addr] <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.act == ACT_INSERT) begin
         for (int j = 0; j < OVERFLOW_DEPTH; j++) begin
            if (OCW'(j) == opos_ff) begin
               ov_ff[j] <= key;
               ot_ff[j] <= more ? '0 : task_ff;
               oe_ff[j] <= exp_ff;
            end else if (j > 0) begin
               if (OCW'(j) > opos_ff && OCW'(j) <= ocnt_ff) begin
                  ov_ff[j] <= ov_ff[j-1];
                  ot_ff[j] <= ot_ff[j-1];
                  oe_ff[j] <= oe_ff[j-1];
               end
            end
         end
      end else if (cmd.act == ACT_OREL_DEL) begin
         for (int j = 0; j < OVERFLOW_DEPTH - 1; j++) begin
            if (OCW'(j) >= opos_ff && OCW'(j + 1) < ocnt_ff) begin
               ov_ff[j] <= ov_ff[j+1];
               ot_ff[j] <= ot_ff[j+1];
               oe_ff[j] <= oe_ff[j+1];
            end
         end
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_task    = rsp_task_ff;
   assign rsp_version = rsp_ver_ff;
   assign rsp_status  = rsp_stat_ff;
   assign rsp_last    = rsp_last_ff;

   a_ocnt_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= OCW'(OVERFLOW_DEPTH)) else $error("overflow count beyond depth");
   a_ws_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, ws_ff} < (IW+1)'(RING_SIZE) && {1'b0, we_ff} < (IW+1)'(RING_SIZE))
      else $error("window pointer beyond ring");
   a_stat_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.act == ACT_EMIT_STAT |-> out_free) else $error("status overwrites result");
   a_stat_out: assert property (@(posedge clock) disable iff (reset)
      cmd.act == ACT_EMIT_STAT |=> rsp_valid_ff && rsp_last_ff && !rsp_kind_ff)
      else $error("status transfer not presented");

endmodule

### src/pawt_ctrl.sv
// Controller: sequences each operation one step per cycle unless rsp stalls.
`timescale 1ns / 1ps
module pawt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic [1:0]            req_op,
   output logic                  req_tready,
   input  pawt_pkg::dp_stat_type st,
   output pawt_pkg::cmd_type     cmd
);
   import pawt_pkg::*;

   typedef enum logic [16:0] {
      S_IDLE     = 17'h00001,
      S_ADD_CHK  = 17'h00002,
      S_FILL     = 17'h00004,
      S_INS_CHK  = 17'h00008,
      S_INS_SCAN = 17'h00010,
      S_RM_RING  = 17'h00020,
      S_RM_FREE  = 17'h00040,
      S_RM_SKIP  = 17'h00080,
      S_RM_OV0   = 17'h00100,
      S_RM_SCAN  = 17'h00200,
      S_RM_DEL   = 17'h00400,
      S_TK_CHK   = 17'h00800,
      S_TK_RING  = 17'h01000,
      S_TK_OV    = 17'h02000,
      S_CL_RING  = 17'h04000,
      S_CL_OV    = 17'h08000,
      S_FINISH   = 17'h10000
   } state_type;

   state_type state_ff, state_in;
   stat_type  code_ff, code_in;
   logic      adv_ff, adv_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      adv_in   = adv_ff;
      cmd.act  = ACT_NONE;
      cmd.ra   = RA_WS;
      cmd.code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.act = ACT_LOAD;
               unique case (op_type'(req_op))
                  OP_ADD:    state_in = S_ADD_CHK;
                  OP_REMOVE: state_in = S_RM_RING;
                  OP_TICK:   state_in = S_TK_CHK;
                  default:   state_in = S_CL_RING;
               endcase
            end
         end
         S_ADD_CHK: begin
            cmd.ra = RA_PREV;
            if (st.cnt_small &&
                (st.win_empty || (st.idx_eq_we && st.next_ne_ws && st.first_eq_rv1))) begin
               cmd.act  = ACT_ADD_MATCH;
               state_in = S_FILL;
            end else begin
               state_in = S_INS_CHK;
            end
         end
         S_FILL: begin
            if (st.more) begin
               cmd.act = ACT_FILL;
            end else begin
               cmd.act  = ACT_FILL_LAST;
               code_in  = ST_OK;
               state_in = S_FINISH;
            end
         end
         S_INS_CHK: begin
            if (st.ov_full) begin
               code_in  = ST_FULL;
               state_in = S_FINISH;
            end else begin
               cmd.act  = (st.ov_cnt_zero || st.key_lt_ov0) ? ACT_OPOS_CLR : ACT_OPOS_ONE;
               state_in = S_INS_SCAN;
            end
         end
         S_INS_SCAN: begin
            if (st.scan_go) begin
               cmd.act = ACT_OPOS_INC;
            end else begin
               cmd.act = ACT_INSERT;
               if (st.more) begin
                  state_in = S_INS_CHK;
               end else begin
                  code_in  = ST_OK;
                  state_in = S_FINISH;
               end
            end
         end
         S_RM_RING: begin
            cmd.ra = RA_IDXF;
            if (!st.win_empty && st.ring_hit) begin
               adv_in   = st.ws_eq_idx;
               state_in = S_RM_FREE;
            end else begin
               state_in = S_RM_OV0;
            end
         end
         S_RM_FREE: begin
            cmd.ra = RA_IDXF;
            if (st.ring_rel_ok) begin
               cmd.act = adv_ff ? ACT_FREE_ADV : ACT_FREE;
               if (adv_ff) begin
                  state_in = S_RM_SKIP;
               end else begin
                  code_in  = ST_OK;
                  state_in = S_FINISH;
               end
            end
         end
         S_RM_SKIP: begin
            if (!st.win_empty && st.rv_zero) begin
               cmd.act = ACT_WS_INC;
            end else begin
               code_in  = ST_OK;
               state_in = S_FINISH;
            end
         end
         S_RM_OV0: begin
            if (st.ov_cnt_zero) begin
               code_in  = ST_NOT_FOUND;
               state_in = S_FINISH;
            end else if (st.key_eq_ov0) begin
               cmd.act  = ACT_OPOS_CLR;
               state_in = S_RM_DEL;
            end else begin
               cmd.act  = ACT_OPOS_ONE;
               state_in = S_RM_SCAN;
            end
         end
         S_RM_SCAN: begin
            if (st.scan_go) begin
               cmd.act = ACT_OPOS_INC;
            end else if (!st.opos_lt_cnt || !st.pos_eq_key) begin
               code_in  = ST_NOT_FOUND;
               state_in = S_FINISH;
            end else begin
               state_in = S_RM_DEL;
            end
         end
         S_RM_DEL: begin
            if (st.ov_rel_ok) begin
               cmd.act  = ACT_OREL_DEL;
               code_in  = ST_OK;
               state_in = S_FINISH;
            end
         end
         S_TK_CHK: begin
            if (st.lct_eq_now) begin
               code_in  = ST_OK;
               state_in = S_FINISH;
            end else begin
               cmd.act  = ACT_SET_LCT;
               state_in = S_TK_RING;
            end
         end
         S_TK_RING: begin
            if (!st.win_empty && st.rexp_lt_now) begin
               if (st.ring_rel_ok) begin
                  cmd.act = ACT_FREE_ADV;
               end
            end else begin
               cmd.act  = ACT_OPOS_CLR;
               state_in = S_TK_OV;
            end
         end
         S_TK_OV: begin
            if (!st.ov_cnt_zero && st.oexp_lt_now) begin
               if (st.ov_rel_ok) begin
                  cmd.act = ACT_OREL_DEL;
               end
            end else begin
               code_in  = ST_OK;
               state_in = S_FINISH;
            end
         end
         S_CL_RING: begin
            if (!st.win_empty) begin
               if (st.ring_rel_ok) begin
                  cmd.act = ACT_FREE_ADV;
               end
            end else begin
               cmd.act  = ACT_OPOS_CLR;
               state_in = S_CL_OV;
            end
         end
         S_CL_OV: begin
            if (st.opos_lt_cnt) begin
               if (st.ov_rel_ok) begin
                  cmd.act = ACT_OREL;
               end
            end else begin
               cmd.act  = ACT_OCLR;
               code_in  = ST_OK;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (st.out_free) begin
               cmd.act  = ACT_EMIT_STAT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      adv_ff  <= adv_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### tb/pawt_checker.sv
// Checker: predicts each request's responses for the ack window tracker and compares them.
`timescale 1ns / 1ps
module pawt_checker
   import pawt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [175:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [87:0]  rsp_tdata,
   input  logic [0:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [15:0]  csr_wdata,
   output int           fail_count,
   output int           pending
);

   localparam int RING = 32;
   localparam int ODEPTH = 16;

   typedef struct {
      logic             kind;
      logic [15:0]      rel_task;
      logic [62:0]      rel_ver;
      stat_type         st;
      logic             last;
   } rsp_item;

   rsp_item expected_rsp[$];

   logic [62:0] ring_ver[RING];
   logic [16:0] ring_tsk[RING];
   logic [31:0] ring_exp[RING];
   int          win_start, win_end;
   logic [62:0] ovf_ver[ODEPTH];
   logic [16:0] ovf_tsk[ODEPTH];
   logic [31:0] ovf_exp[ODEPTH];
   int          ovf_cnt;
   logic [31:0] last_tick;
   logic [15:0] timeout_s;

   function automatic void push_release(logic [16:0] t, logic [62:0] v);
      rsp_item r;
      if (t[16]) begin
         r.kind = 1'b1;
         r.rel_task = t[15:0];
         r.rel_ver = v;
         r.st = ST_OK;
         r.last = 1'b0;
         expected_rsp.push_back(r);
      end
   endfunction

   function automatic void push_status(stat_type s);
      rsp_item r;
      r.kind = 1'b0;
      r.rel_task = '0;
      r.rel_ver = '0;
      r.st = s;
      r.last = 1'b1;
      expected_rsp.push_back(r);
   endfunction

   function automatic void free_slot(int s);
      push_release(ring_tsk[s], ring_ver[s]);
      ring_ver[s] = '0;
      ring_tsk[s] = '0;
   endfunction

   function automatic void ovf_delete(int p);
      for (int j = p; j + 1 < ovf_cnt; j++) begin
         ovf_ver[j] = ovf_ver[j+1];
         ovf_tsk[j] = ovf_tsk[j+1];
         ovf_exp[j] = ovf_exp[j+1];
      end
      ovf_cnt--;
   endfunction

   function automatic bit ovf_insert(logic [62:0] v, logic [16:0] t, logic [31:0] e);
      int p;
      if (ovf_cnt >= ODEPTH) return 1'b0;
      if (ovf_cnt == 0 || v > ovf_ver[ovf_cnt-1]) p = ovf_cnt;
      else if (v < ovf_ver[0]) p = 0;
      else begin
         p = 1;
         while (p < ovf_cnt && v > ovf_ver[p]) p++;
      end
      for (int j = ovf_cnt; j > p; j--) begin
         ovf_ver[j] = ovf_ver[j-1];
         ovf_tsk[j] = ovf_tsk[j-1];
         ovf_exp[j] = ovf_exp[j-1];
      end
      ovf_ver[p] = v;
      ovf_tsk[p] = t;
      ovf_exp[p] = e;
      ovf_cnt++;
      return 1'b1;
   endfunction

   function automatic void predict_add(logic [62:0] first, logic [62:0] last,
                                       logic [16:0] t, logic [31:0] now);
      logic [63:0] cnt;
      logic [32:0] sum;
      logic [31:0] e;
      logic [62:0] v;
      int          idx, prv, nxt;
      bit          matched;
      cnt = (last >= first) ? {1'b0, last} - {1'b0, first} : 64'd0;
      idx = int'(first[4:0]);
      sum = {1'b0, now} + {17'd0, timeout_s};
      e = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      matched = 1'b0;
      if (cnt < RING) begin
         if (win_start == win_end) begin
            win_start = idx;
            matched = 1'b1;
         end else if (idx == win_end) begin
            prv = (idx + RING - 1) % RING;
            nxt = (idx + 1) % RING;
            if (nxt != win_start && {1'b0, first} == {1'b0, ring_ver[prv]} + 64'd1)
               matched = 1'b1;
         end
      end
      if (matched) begin
         win_end = (int'(last[4:0]) + 1) % RING;
         for (int i = 0; i < int'(cnt); i++) begin
            v = first + 63'(i);
            ring_ver[v[4:0]] = v;
            ring_exp[v[4:0]] = e;
         end
         ring_ver[last[4:0]] = last;
         ring_tsk[last[4:0]] = t;
         ring_exp[last[4:0]] = e;
         push_status(ST_OK);
         return;
      end
      for (logic [63:0] i = 0; i < cnt; i++) begin
         if (!ovf_insert(first + i[62:0], 17'd0, e)) begin
            push_status(ST_FULL);
            return;
         end
      end
      if (!ovf_insert(last, t, e)) push_status(ST_FULL);
      else push_status(ST_OK);
   endfunction

   function automatic void predict_remove(logic [62:0] v);
      int idx, p;
      if (win_start != win_end) begin
         idx = int'(v[4:0]);
         if (ring_ver[idx] == v) begin
            if (win_start == idx) begin
               win_start = (idx + 1) % RING;
               while (win_start != win_end && ring_ver[win_start] == '0)
                  win_start = (win_start + 1) % RING;
            end
            free_slot(idx);
            push_status(ST_OK);
            return;
         end
      end
      if (ovf_cnt == 0) begin
         push_status(ST_NOT_FOUND);
         return;
      end
      if (v == ovf_ver[0]) p = 0;
      else begin
         p = 1;
         while (p < ovf_cnt && v > ovf_ver[p]) p++;
         if (p >= ovf_cnt || ovf_ver[p] != v) begin
            push_status(ST_NOT_FOUND);
            return;
         end
      end
      push_release(ovf_tsk[p], ovf_ver[p]);
      ovf_delete(p);
      push_status(ST_OK);
   endfunction

   function automatic void predict_tick(logic [31:0] now);
      if (last_tick != now) begin
         last_tick = now;
         while (win_start != win_end && ring_exp[win_start] < now) begin
            free_slot(win_start);
            win_start = (win_start + 1) % RING;
         end
         while (ovf_cnt > 0 && ovf_exp[0] < now) begin
            push_release(ovf_tsk[0], ovf_ver[0]);
            ovf_delete(0);
         end
      end
      push_status(ST_OK);
   endfunction

   function automatic void predict_clear();
      while (win_start != win_end) begin
         free_slot(win_start);
         win_start = (win_start + 1) % RING;
      end
      for (int i = 0; i < ovf_cnt; i++) push_release(ovf_tsk[i], ovf_ver[i]);
      ovf_cnt = 0;
      push_status(ST_OK);
   endfunction

   function automatic void check_rsp();
      rsp_item r;
      if (expected_rsp.size() == 0) begin
         $display("%0t: unexpected response kind=%0d tdata=%h", $time, rsp_tuser, rsp_tdata);
         fail_count++;
         return;
      end
      r = expected_rsp.pop_front();
      if (rsp_tuser[0] !== r.kind || rsp_tdata[15:0] !== r.rel_task ||
          rsp_tdata[78:16] !== r.rel_ver || rsp_tdata[80:79] !== r.st ||
          rsp_tlast !== r.last) begin
         $display("%0t: mismatch expected kind=%0d task=%h ver=%h st=%0d last=%0d",
                  $time, r.kind, r.rel_task, r.rel_ver, r.st, r.last);
         $display("%0t:          actual   kind=%0d task=%h ver=%h st=%0d last=%0d",
                  $time, rsp_tuser[0], rsp_tdata[15:0], rsp_tdata[78:16],
                  rsp_tdata[80:79], rsp_tlast);
         fail_count++;
      end
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING; i++) begin
            ring_ver[i] = '0;
            ring_tsk[i] = '0;
            ring_exp[i] = '0;
         end
         win_start = 0;
         win_end = 0;
         ovf_cnt = 0;
         last_tick = '0;
         timeout_s = 16'd30;
         expected_rsp.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_rsp();
         if (csr_valid && csr_ready) timeout_s = csr_wdata;
         if (req_tvalid && req_tready) begin
            case (op_type'(req_tuser))
               OP_ADD:
                  predict_add(req_tdata[62:0], req_tdata[125:63],
                              req_tdata[142] ? {1'b1, req_tdata[141:126]} : 17'd0,
                              req_tdata[174:143]);
               OP_REMOVE: predict_remove(req_tdata[62:0]);
               OP_TICK:   predict_tick(req_tdata[174:143]);
               default:   predict_clear();
            endcase
         end
      end
      pending <= expected_rsp.size();
   end

endmodule

### tb/tb_pending_ack_window_tracker_top.sv
// Testbench top: drives requests and timeout writes into the ack window tracker and gives the verdict.
`timescale 1ns / 1ps
module tb_pending_ack_window_tracker_top;
   import pawt_pkg::*;

   localparam logic [62:0] VMAX = {63{1'b1}};
   localparam int QUIET_LIMIT = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [175:0] req_tdata = '0;
   logic [1:0]   req_tuser = OP_TICK;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [87:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_wdata = '0;
   int           fail_count;
   int           pending;
   bit           steady = 1'b0;
   int           quiet_cycles = 0;

   logic [62:0]  next_ver;
   logic [31:0]  now_t = 32'd10;
   logic [62:0]  live_ver[$];

   always #5 clock = ~clock;

   pending_ack_window_tracker_top dut (.*);

   pawt_checker u_checker (.*);

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 27);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [62:0] rand_ver();
      return 63'({$urandom, $urandom});
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   task automatic send_req(op_type op, logic [62:0] first, logic [62:0] last,
                           logic [15:0] tid, logic present, logic [31:0] now);
      if (!steady && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tuser <= op;
      req_tdata <= {1'b0, now, present, tid, last, first};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_timeout(logic [15:0] val);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_wdata <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_item();
      int          r, len, k;
      logic [62:0] v;
      r = $urandom_range(99);
      if (r < 35) begin
         len = $urandom_range(1, 5);
         send_req(OP_ADD, next_ver, next_ver + 63'(len - 1), 16'($urandom),
                  rand_bit(), now_t);
         for (int i = 0; i < len; i++) live_ver.push_back(next_ver + 63'(i));
         next_ver = next_ver + 63'(len);
      end else if (r < 60) begin
         if (live_ver.size() > 0 && $urandom_range(99) < 80) begin
            k = $urandom_range(live_ver.size() - 1);
            v = live_ver[k];
            live_ver.delete(k);
         end else begin
            v = next_ver - 63'($urandom_range(40));
         end
         send_req(OP_REMOVE, v, rand_ver(), 16'($urandom), rand_bit(), now_t);
      end else if (r < 72) begin
         now_t = now_t + 32'($urandom_range(0, 20));
         send_req(OP_TICK, rand_ver(), rand_ver(), 16'($urandom), rand_bit(), now_t);
      end else if (r < 76) begin
         send_req(OP_CLEAR, rand_ver(), rand_ver(), 16'($urandom), rand_bit(), now_t);
         live_ver.delete();
         next_ver = 63'($urandom);
      end else if (r < 90) begin
         v = 63'(1000 + $urandom_range(30));
         send_req(OP_ADD, v, v + 63'($urandom_range(0, 2)), 16'($urandom),
                  rand_bit(), now_t);
         send_req(OP_REMOVE, 63'(1000 + $urandom_range(30)), '0, '0, 1'b0, now_t);
      end else begin
         send_req(op_type'($urandom_range(3)), rand_ver(), rand_ver(), 16'($urandom),
                  rand_bit(), $urandom);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_req(OP_ADD, 63'd0, 63'd3, 16'h0000, 1'b1, 32'd5);
      send_req(OP_ADD, 63'd4, 63'd4, 16'hFFFF, 1'b1, 32'd5);
      send_req(OP_REMOVE, 63'd0, '0, '0, 1'b0, 32'd5);
      send_req(OP_ADD, VMAX, VMAX, 16'hA5A5, 1'b1, 32'd5);
      send_req(OP_ADD, 63'd100, 63'd50, 16'h1234, 1'b1, 32'd6);
      send_req(OP_ADD, 63'd205, 63'd205, 16'h0001, 1'b1, 32'd6);
      send_req(OP_ADD, 63'd200, 63'd240, 16'h5A5A, 1'b1, 32'd6);
      send_req(OP_ADD, 63'd205, 63'd205, 16'h0002, 1'b1, 32'd6);
      send_req(OP_REMOVE, 63'd205, '0, '0, 1'b0, 32'd6);
      send_req(OP_REMOVE, 63'd999, '0, '0, 1'b0, 32'd6);
      send_req(OP_REMOVE, VMAX, '0, '0, 1'b0, 32'd6);
      send_req(OP_TICK, '0, '0, '0, 1'b0, 32'd7);
      send_req(OP_TICK, '0, '0, '0, 1'b0, 32'd7);
      send_req(OP_TICK, '0, '0, '0, 1'b0, 32'hFFFF_FFFF);
      send_req(OP_ADD, 63'd33, 63'd35, 16'h0BEE, 1'b1, 32'hFFFF_FFF0);
      send_req(OP_REMOVE, 63'd0, '0, '0, 1'b0, 32'd8);
      send_req(OP_ADD, 63'd36, 63'd38, 16'h0C0C, 1'b0, 32'd8);
      send_req(OP_REMOVE, 63'd37, '0, '0, 1'b0, 32'd8);
      send_req(OP_REMOVE, 63'd36, '0, '0, 1'b0, 32'd8);
      send_req(OP_ADD, 63'd39, 63'd70, 16'h7777, 1'b1, 32'd8);
      send_req(OP_CLEAR, '0, '0, '0, 1'b0, 32'd8);
      send_req(OP_TICK, '0, '0, '0, 1'b0, 32'd0);

      next_ver = 63'($urandom);
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_timeout(16'd1);
            1: write_timeout(16'hFFFF);
            2: write_timeout(16'($urandom_range(2, 60)));
            default: write_timeout(16'd30);
         endcase
         for (int n = 0; n < 75; n++) begin
            steady = (ph == 1 && n >= 20 && n < 60);
            random_item();
         end
         steady = 1'b0;
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### pending_ack_window_tracker_top.f
src/pawt_pkg.sv
src/pawt_dp.sv
src/pawt_ctrl.sv
src/pending_ack_window_tracker_top.sv
tb/pawt_checker.sv
tb/tb_pending_ack_window_tracker_top.sv
